/* hdl/grc_pkg.sv */
// ---------------------------------------------------------------------------
// grc_pkg: shared types and constants of the grid ray caster
// Item and result layouts, register indexes, reset values, wall map layout.
// ---------------------------------------------------------------------------
`default_nettype none
package grc_pkg;

  localparam int MAP_DIM_DEF       = 16;
  localparam int SCREEN_HEIGHT_DEF = 600;
  localparam int MAX_STEPS_DEF     = 32;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd6;

  localparam logic [15:0] POS_X_RST   = 16'd12288;
  localparam logic [15:0] POS_Y_RST   = 16'd10240;
  localparam logic [15:0] DIR_X_RST   = 16'd16384;
  localparam logic [15:0] DIR_Y_RST   = 16'd0;
  localparam logic [15:0] PLANE_X_RST = 16'd0;
  localparam logic [15:0] PLANE_Y_RST = 16'd11469;
  localparam logic [9:0]  SCREEN_W_RST = 10'd600;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // ray components, Q.14, full width
  localparam int RAY_W = 28;
  // shared divider
  localparam int DVD_W = 32;
  localparam int DVS_W = 28;

  localparam int SHADE_NUM = 300 * 256;
  localparam int SHADE_MAX = 255;

  localparam int LAYOUT_DIM = 10;
  // row x, column y at bit 9-y
  localparam logic [9:0] LAYOUT_ROWS [LAYOUT_DIM] = '{
    10'b1111111111,
    10'b1000000001,
    10'b1000000001,
    10'b1000010001,
    10'b1000010001,
    10'b1010010001,
    10'b1000011111,
    10'b1000000001,
    10'b1010000001,
    10'b1111111111
  };

  typedef struct packed {
    logic       command;
    logic [9:0] column;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic       cell_wall;
  } item_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic        hit_found;
    logic        wall_side;
    logic [3:0]  hit_x;
    logic [3:0]  hit_y;
    logic [15:0] wall_distance;
    logic [9:0]  line_top;
    logic [9:0]  line_bottom;
    logic [7:0]  shade;
  } result_t;

  typedef struct packed {
    logic             go;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  function automatic logic layout_bit(input logic [5:0] x, input logic [5:0] y);
    logic [9:0] row;
    row = 10'h3FF;
    if (x < 6'(LAYOUT_DIM) && y < 6'(LAYOUT_DIM)) begin
      row = LAYOUT_ROWS[x[3:0]];
      return row[4'd9 - y[3:0]];
    end
    return 1'b1;
  endfunction

endpackage
`default_nettype wire

/* hdl/grc_ram.sv */
// ---------------------------------------------------------------------------
// grc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/grc_div.sv */
// ---------------------------------------------------------------------------
// grc_div: shared unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with the result.
// ---------------------------------------------------------------------------
`default_nettype none
module grc_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire grc_pkg::div_req_t       req,
  output logic                         done,
  output logic [grc_pkg::DVD_W-1:0]    quotient
);
  import grc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quotient[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && cnt == CNT_W'(1);
      if (req.go) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(1)) begin
        run <= 1'b0;
      end
    end
    if (req.go) begin
      rem      <= '0;
      quotient <= req.dividend;
      dvs      <= req.divisor;
      cnt      <= CNT_W'(DVD_W);
    end else if (run) begin
      rem      <= fits ? DVS_W'(shifted - {1'b0, dvs}) : shifted[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
      cnt      <= cnt - CNT_W'(1);
    end
  end
endmodule
`default_nettype wire

/* hdl/grid_ray_caster_core.sv */
// ---------------------------------------------------------------------------
// grid_ray_caster_core: DDA ray caster over a stored wall map
// Casts one column ray per command, or writes one map cell.
//
//   channel   ports                             transfer
//   item      start, busy, item                 start && !busy
//   result    done, result                      done (one cycle)
//   config    cfg_write, cfg_index, cfg_data    cfg_write
//
// A cell write is done in the idle state. A cast runs up to six divisions in the shared
// divider (cam, two reciprocals, distance, line height, shade), plus a step, a map read
// and a wall test per DDA step, and control states.
// After reset a clearing pass loads the map layout into every cell, with busy high.
// Results cannot be stalled.
// ---------------------------------------------------------------------------
`default_nettype none
module grid_ray_caster_core #(
  parameter int MAP_DIM       = grc_pkg::MAP_DIM_DEF,
  parameter int SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT_DEF,
  parameter int MAX_STEPS     = grc_pkg::MAX_STEPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire grc_pkg::item_t                item,
  output logic                               done,
  output grc_pkg::result_t                   result,
  input  wire logic                          cfg_write,
  input  wire logic [grc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [grc_pkg::CFG_W-1:0]     cfg_data
);
  import grc_pkg::*;

  localparam int DEPTH  = MAP_DIM * MAP_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int AXW    = $clog2(MAP_DIM);
  localparam int MW     = (AXW > 4 ? AXW : 4) + 2;
  localparam int NUM_W  = MW + 14;
  localparam int N_W    = $clog2(MAX_STEPS + 1);
  localparam int SIDE_W = 34 + N_W;
  localparam int MID    = SCREEN_HEIGHT / 2;
  localparam int HALF_NUM = MID * 256;

  typedef enum logic [17:0] {
    S_CLEAR = 18'b000000000000000001,
    S_IDLE  = 18'b000000000000000010,
    S_CAM   = 18'b000000000000000100,
    S_RAYX  = 18'b000000000000001000,
    S_RAYY  = 18'b000000000000010000,
    S_RAYF  = 18'b000000000000100000,
    S_RECX  = 18'b000000000001000000,
    S_RECY  = 18'b000000000010000000,
    S_SIDEX = 18'b000000000100000000,
    S_SIDEY = 18'b000000001000000000,
    S_SIDEF = 18'b000000010000000000,
    S_STEP  = 18'b000000100000000000,
    S_CHK0  = 18'b000001000000000000,
    S_CHK1  = 18'b000010000000000000,
    S_PERP  = 18'b000100000000000000,
    S_HALF  = 18'b001000000000000000,
    S_SHADE = 18'b010000000000000000,
    S_OUT   = 18'b100000000000000000
  } state_t;

  state_t state;

  logic [15:0] pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;
  logic [9:0]  screen_w;

  logic [9:0]              col;
  logic signed [26:0]      cam;
  logic signed [RAY_W-1:0] ray_x, ray_y;
  logic [31:0]             delta_x, delta_y;
  logic [SIDE_W-1:0]       side_x, side_y;
  logic signed [MW-1:0]    map_x, map_y;
  logic [N_W-1:0]          n;
  logic                    hit, side;
  logic [15:0]             wall_dist;
  logic [9:0]              top, bottom;
  logic [7:0]              shade_r;
  logic                    div_wait;
  logic [AXW-1:0]          cx, cy;

  logic signed [49:0]      mul_p;
  logic signed [16:0]      mul_a;
  logic signed [32:0]      mul_b;
  logic signed [49:0]      mul_rnd;
  logic signed [49:0]      mul_tr;
  logic signed [RAY_W-1:0] ray_new;

  logic [RAY_W-1:0]        mag_x, mag_y, mag_axis;
  logic                    axis_neg;
  logic [12:0]             frac_x, frac_y;
  logic signed [NUM_W-1:0] num, num_eff;
  logic                    out_map;

  div_req_t                dreq;
  logic                    div_done;
  logic [DVD_W-1:0]        quo;

  logic                    ram_we, ram_wd, ram_q;
  logic [AW-1:0]           ram_wa, ram_ra;

  logic signed [19:0]      t_val, b_val;

  assign busy = state != S_IDLE;

  // operand selection
  assign mag_x    = ray_x[RAY_W-1] ? RAY_W'(-ray_x) : RAY_W'(ray_x);
  assign mag_y    = ray_y[RAY_W-1] ? RAY_W'(-ray_y) : RAY_W'(ray_y);
  assign mag_axis = side ? mag_y : mag_x;
  assign axis_neg = side ? ray_y[RAY_W-1] : ray_x[RAY_W-1];
  assign frac_x   = ray_x[RAY_W-1] ? {1'b0, pos_x[11:0]} : 13'd4096 - {1'b0, pos_x[11:0]};
  assign frac_y   = ray_y[RAY_W-1] ? {1'b0, pos_y[11:0]} : 13'd4096 - {1'b0, pos_y[11:0]};

  always_comb begin
    num = side ? (NUM_W'(map_y) <<< 12) - NUM_W'(pos_y) : (NUM_W'(map_x) <<< 12) - NUM_W'(pos_x);
    if (axis_neg) begin
      num = num + NUM_W'(4096);
    end
    num_eff = axis_neg ? -num : num;
  end

  assign out_map = map_x[MW-1] || map_y[MW-1] ||
                   map_x >= $signed(MW'(MAP_DIM)) || map_y >= $signed(MW'(MAP_DIM));

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_RAYX: begin
        mul_a = 17'(signed'(plane_x));
        mul_b = 33'(cam);
      end
      S_RAYY: begin
        mul_a = 17'(signed'(plane_y));
        mul_b = 33'(cam);
      end
      S_SIDEX: begin
        mul_a = signed'({4'b0, frac_x});
        mul_b = signed'({1'b0, delta_x});
      end
      S_SIDEY: begin
        mul_a = signed'({4'b0, frac_y});
        mul_b = signed'({1'b0, delta_y});
      end
      default: ;
    endcase
  end

  assign mul_rnd = mul_p + (mul_p[49] ? 50'sd16383 : 50'sd0);
  assign mul_tr  = mul_rnd >>> 14;
  assign ray_new = RAY_W'(signed'(state == S_RAYY ? dir_x : dir_y)) + mul_tr[RAY_W-1:0];

  // divider requests
  always_comb begin
    dreq.go       = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    case (state)
      S_CAM: begin
        dreq.go       = !div_wait;
        dreq.dividend = DVD_W'({col, 15'b0});
        dreq.divisor  = (screen_w == 10'd0) ? DVS_W'(1) : DVS_W'(screen_w);
      end
      S_RECX: begin
        dreq.go       = !div_wait && mag_x != '0;
        dreq.dividend = DVD_W'(32'h4000_0000);
        dreq.divisor  = DVS_W'(mag_x);
      end
      S_RECY: begin
        dreq.go       = !div_wait && mag_y != '0;
        dreq.dividend = DVD_W'(32'h4000_0000);
        dreq.divisor  = DVS_W'(mag_y);
      end
      S_PERP: begin
        dreq.go       = !div_wait && mag_axis != '0 && num_eff > 0;
        dreq.dividend = DVD_W'(num_eff) << 10;
        dreq.divisor  = DVS_W'(mag_axis);
      end
      S_HALF: begin
        dreq.go       = !div_wait && wall_dist != 16'd0;
        dreq.dividend = DVD_W'(HALF_NUM);
        dreq.divisor  = DVS_W'(wall_dist);
      end
      S_SHADE: begin
        dreq.go       = !div_wait;
        dreq.dividend = DVD_W'(SHADE_NUM);
        dreq.divisor  = DVS_W'(wall_dist);
      end
      default: ;
    endcase
  end

  assign t_val = 20'(MID) - 20'(quo[17:0]);
  assign b_val = 20'(MID) + 20'(quo[17:0]);

  // map port
  always_comb begin
    ram_we = 1'b0;
    ram_wd = 1'b0;
    ram_wa = AW'(cx) * AW'(MAP_DIM) + AW'(cy);
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_wd = layout_bit(6'(cx), 6'(cy));
    end else if (state == S_IDLE && start && item.command == CMD_WRITE) begin
      ram_we = 32'(item.cell_x) < MAP_DIM && 32'(item.cell_y) < MAP_DIM;
      ram_wd = item.cell_wall;
      ram_wa = AW'(item.cell_x) * AW'(MAP_DIM) + AW'(item.cell_y);
    end
  end

  assign ram_ra = AW'(map_x[AXW-1:0]) * AW'(MAP_DIM) + AW'(map_y[AXW-1:0]);

  grc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_q)
  );

  grc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .done     (div_done),
    .quotient (quo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x    <= POS_X_RST;
      pos_y    <= POS_Y_RST;
      dir_x    <= DIR_X_RST;
      dir_y    <= DIR_Y_RST;
      plane_x  <= PLANE_X_RST;
      plane_y  <= PLANE_Y_RST;
      screen_w <= SCREEN_W_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POS_X:    pos_x    <= cfg_data;
        REG_POS_Y:    pos_y    <= cfg_data;
        REG_DIR_X:    dir_x    <= cfg_data;
        REG_DIR_Y:    dir_y    <= cfg_data;
        REG_PLANE_X:  plane_x  <= cfg_data;
        REG_PLANE_Y:  plane_y  <= cfg_data;
        REG_SCREEN_W: screen_w <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (rst) begin
      state    <= S_CLEAR;
      done     <= 1'b0;
      div_wait <= 1'b0;
      cx       <= '0;
      cy       <= '0;
    end else begin
      done <= 1'b0;
      if (dreq.go) begin
        div_wait <= 1'b1;
      end else if (div_done) begin
        div_wait <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cy == AXW'(MAP_DIM - 1)) begin
            cy <= '0;
            if (cx == AXW'(MAP_DIM - 1)) begin
              state <= S_IDLE;
            end
            cx <= cx + AXW'(1);
          end else begin
            cy <= cy + AXW'(1);
          end
        end
        S_IDLE: begin
          if (start && item.command == CMD_CAST) begin
            col   <= item.column;
            hit   <= 1'b0;
            side  <= 1'b0;
            n     <= '0;
            map_x <= MW'(pos_x[15:12]);
            map_y <= MW'(pos_y[15:12]);
            state <= S_CAM;
          end
        end
        S_CAM: begin
          if (div_done) begin
            cam   <= signed'({1'b0, quo[25:0]}) - 27'sd16384;
            state <= S_RAYX;
          end
        end
        S_RAYX: state <= S_RAYY;
        S_RAYY: begin
          ray_x <= ray_new;
          state <= S_RAYF;
        end
        S_RAYF: begin
          ray_y <= ray_new;
          state <= S_RECX;
        end
        S_RECX: begin
          if (mag_x == '0) begin
            delta_x <= 32'hFFFF_FFFF;
            state   <= S_RECY;
          end else if (div_done) begin
            delta_x <= quo;
            state   <= S_RECY;
          end
        end
        S_RECY: begin
          if (mag_y == '0) begin
            delta_y <= 32'hFFFF_FFFF;
            state   <= S_SIDEX;
          end else if (div_done) begin
            delta_y <= quo;
            state   <= S_SIDEX;
          end
        end
        S_SIDEX: state <= S_SIDEY;
        S_SIDEY: begin
          side_x <= SIDE_W'(mul_p[45:12]);
          state  <= S_SIDEF;
        end
        S_SIDEF: begin
          side_y <= SIDE_W'(mul_p[45:12]);
          state  <= out_map ? S_OUT : S_STEP;
        end
        S_STEP: begin
          if (side_x < side_y) begin
            side_x <= side_x + SIDE_W'(delta_x);
            map_x  <= ray_x[RAY_W-1] ? map_x - MW'(1) : map_x + MW'(1);
            side   <= 1'b0;
          end else begin
            side_y <= side_y + SIDE_W'(delta_y);
            map_y  <= ray_y[RAY_W-1] ? map_y - MW'(1) : map_y + MW'(1);
            side   <= 1'b1;
          end
          n     <= n + N_W'(1);
          state <= S_CHK0;
        end
        S_CHK0: state <= out_map ? S_OUT : S_CHK1;
        S_CHK1: begin
          if (ram_q) begin
            hit   <= 1'b1;
            state <= S_PERP;
          end else if (n == N_W'(MAX_STEPS)) begin
            state <= S_OUT;
          end else begin
            state <= S_STEP;
          end
        end
        S_PERP: begin
          if (mag_axis == '0) begin
            wall_dist <= 16'hFFFF;
            state     <= S_HALF;
          end else if (num_eff <= 0) begin
            wall_dist <= 16'd0;
            state     <= S_HALF;
          end else if (div_done) begin
            wall_dist <= (quo[31:16] != 16'd0) ? 16'hFFFF : quo[15:0];
            state     <= S_HALF;
          end
        end
        S_HALF: begin
          if (wall_dist == 16'd0) begin
            top     <= '0;
            bottom  <= 10'(SCREEN_HEIGHT - 1);
            shade_r <= '0;
            state   <= S_OUT;
          end else if (div_done) begin
            top    <= t_val < 0 ? 10'd0 :
                      (t_val > 20'(SCREEN_HEIGHT - 1) ? 10'(SCREEN_HEIGHT - 1) : t_val[9:0]);
            bottom <= b_val > 20'(SCREEN_HEIGHT - 1) ? 10'(SCREEN_HEIGHT - 1) : b_val[9:0];
            state  <= S_SHADE;
          end
        end
        S_SHADE: begin
          if (div_done) begin
            shade_r <= (quo >= DVD_W'(SHADE_MAX)) ? 8'd0 : 8'(SHADE_MAX) - quo[7:0];
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          result.column_out    <= col;
          result.hit_found     <= hit;
          result.wall_side     <= hit & side;
          result.hit_x         <= hit ? 4'(map_x) : 4'd0;
          result.hit_y         <= hit ? 4'(map_y) : 4'd0;
          result.wall_distance <= hit ? wall_dist : 16'hFFFF;
          result.line_top      <= hit ? top : 10'd0;
          result.line_bottom   <= hit ? bottom : 10'd0;
          result.shade         <= hit ? shade_r : 8'd0;
          done                 <= 1'b1;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
